@@ sv/fwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwd_pkg
// Types and constants shared by the front wall distance regulator.
// ----------------------------------------------------------------------------
package fwd_pkg;

   localparam int COEF_FRAC_BITS = 16;
   localparam logic signed [15:0] INVALID_FALLBACK_MM = 16'sd200;

   localparam int ERR_W   = 18;
   localparam int COEF_W  = 24;
   localparam int DRIVE_W = 32;
   localparam int ACC_W   = 64;

   typedef enum logic [2:0] {
      REG_TARGET      = 3'd0,
      REG_ERR_NOW     = 3'd1,
      REG_ERR_PREV    = 3'd2,
      REG_ERR_OLDER   = 3'd3,
      REG_OUT_PREV    = 3'd4,
      REG_OUT_OLDER   = 3'd5,
      REG_RIGHT_OFS   = 3'd6,
      REG_THRESHOLD   = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [15:0] left_distance;
      logic signed [15:0] right_distance;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      settled;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] err_now;
      logic signed [COEF_W-1:0] err_prev;
      logic signed [COEF_W-1:0] err_older;
      logic signed [COEF_W-1:0] out_prev;
      logic signed [COEF_W-1:0] out_older;
   } coef_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err_prev;
      logic signed [ERR_W-1:0]   err_older;
      logic signed [DRIVE_W-1:0] out_prev;
      logic signed [DRIVE_W-1:0] out_older;
   } hist_type;

endpackage

@@ sv/front_wall_distance_regulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_wall_distance_regulator
// Two-channel second-order compensator on front wall range readings with a
// sticky settled flag and an APB-style register port.
// ----------------------------------------------------------------------------
// pipeline: each request goes through the input register, then the result register
// throughput: 1 request per cycle unless a stalled result holds the input;
//   the compensator feedback closes combinationally through the multiply and
//   sum path from the history registers
// reset: synchronous active high; clears valids, histories and the settled
//   flag, and loads the register defaults; no clearing pass
// ----------------------------------------------------------------------------
module front_wall_distance_regulator import fwd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [12:0]              target_ff;
   coef_type                 coef_ff;
   logic signed [7:0]        offset_ff;
   logic [7:0]               thr_ff;

   req_type                  req_ff;
   logic                     req_valid_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff;
   logic                     settled_ff;

   hist_type                 lhist_ff, lhist_in;
   hist_type                 rhist_ff, rhist_in;

   logic                     advance;
   logic                     csr_wr;
   reg_idx_type              csr_idx;

   logic signed [15:0]       dl, dr;
   logic signed [ERR_W-1:0]  el, er;
   logic [ERR_W-1:0]         mag_el, mag_er, mag_lp, mag_rp, thr_ext;
   logic                     ok;
   logic signed [DRIVE_W-1:0] yl, yr;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_idx_type'(paddr[4:2]);

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (csr_idx)
         REG_TARGET:    prdata = {19'b0, target_ff};
         REG_ERR_NOW:   prdata = 32'(coef_ff.err_now);
         REG_ERR_PREV:  prdata = 32'(coef_ff.err_prev);
         REG_ERR_OLDER: prdata = 32'(coef_ff.err_older);
         REG_OUT_PREV:  prdata = 32'(coef_ff.out_prev);
         REG_OUT_OLDER: prdata = 32'(coef_ff.out_older);
         REG_RIGHT_OFS: prdata = 32'(offset_ff);
         REG_THRESHOLD: prdata = {24'b0, thr_ff};
         default:       prdata = 32'b0;
      endcase
   end

   // invalid readings fall back to a fixed distance
   always_comb begin
      dl = req_ff.left_distance[15]  ? INVALID_FALLBACK_MM : req_ff.left_distance;
      dr = req_ff.right_distance[15] ? INVALID_FALLBACK_MM : req_ff.right_distance;
      el = $signed({5'b0, target_ff}) - ERR_W'(dl);
      er = $signed({5'b0, target_ff}) - ERR_W'(dr) + ERR_W'(offset_ff);

      mag_el  = el[ERR_W-1] ? ERR_W'(-el) : ERR_W'(el);
      mag_er  = er[ERR_W-1] ? ERR_W'(-er) : ERR_W'(er);
      mag_lp  = lhist_ff.err_prev[ERR_W-1] ? ERR_W'(-lhist_ff.err_prev)
                                           : ERR_W'(lhist_ff.err_prev);
      mag_rp  = rhist_ff.err_prev[ERR_W-1] ? ERR_W'(-rhist_ff.err_prev)
                                           : ERR_W'(rhist_ff.err_prev);
      thr_ext = {{(ERR_W-8){1'b0}}, thr_ff};
      ok = (mag_el < thr_ext) && (mag_er < thr_ext)
         && (mag_lp < thr_ext) && (mag_rp < thr_ext);
   end

   fwd_chan u_left (
      .coef  (coef_ff),
      .hist  (lhist_ff),
      .err   (el),
      .drive (yl)
   );

   fwd_chan u_right (
      .coef  (coef_ff),
      .hist  (rhist_ff),
      .err   (er),
      .drive (yr)
   );

   always_comb begin
      lhist_in = lhist_ff;
      rhist_in = rhist_ff;
      rsp_in.left_drive  = lhist_ff.out_prev;
      rsp_in.right_drive = rhist_ff.out_prev;
      rsp_in.settled     = 1'b1;
      // once settled the state is frozen and the held drives repeat
      if (!settled_ff) begin
         lhist_in = '{err_prev: el, err_older: lhist_ff.err_prev,
                      out_prev: yl, out_older: lhist_ff.out_prev};
         rhist_in = '{err_prev: er, err_older: rhist_ff.err_prev,
                      out_prev: yr, out_older: rhist_ff.out_prev};
         rsp_in.left_drive  = yl;
         rsp_in.right_drive = yr;
         rsp_in.settled     = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff         <= 13'd50;
         coef_ff.err_now   <= 24'sd2046;
         coef_ff.err_prev  <= -24'sd3607;
         coef_ff.err_older <= 24'sd1561;
         coef_ff.out_prev  <= 24'sd121363;
         coef_ff.out_older <= -24'sd55827;
         offset_ff         <= 8'sd8;
         thr_ff            <= 8'd6;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TARGET:    target_ff         <= pwdata[12:0];
            REG_ERR_NOW:   coef_ff.err_now   <= pwdata[23:0];
            REG_ERR_PREV:  coef_ff.err_prev  <= pwdata[23:0];
            REG_ERR_OLDER: coef_ff.err_older <= pwdata[23:0];
            REG_OUT_PREV:  coef_ff.out_prev  <= pwdata[23:0];
            REG_OUT_OLDER: coef_ff.out_older <= pwdata[23:0];
            REG_RIGHT_OFS: offset_ff         <= pwdata[7:0];
            REG_THRESHOLD: thr_ff            <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         settled_ff   <= 1'b0;
         lhist_ff     <= '0;
         rhist_ff     <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            lhist_ff     <= lhist_in;
            rhist_ff     <= rhist_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a new target restarts regulation from the kept histories
         if (csr_wr && csr_idx == REG_TARGET) begin
            settled_ff <= 1'b0;
         end else if (advance) begin
            settled_ff <= rsp_in.settled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ sv/fwd_chan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwd_chan
// One channel of the second-order compensator: five products, exact sum,
// round half up, scale down and saturate to 32 bits.
// ----------------------------------------------------------------------------
module fwd_chan import fwd_pkg::*; (
   input  coef_type                 coef,
   input  hist_type                 hist,
   input  logic signed [ERR_W-1:0]  err,
   output logic signed [DRIVE_W-1:0] drive
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);

   logic signed [COEF_W+ERR_W-1:0]   p_now;
   logic signed [COEF_W+ERR_W-1:0]   p_prev;
   logic signed [COEF_W+ERR_W-1:0]   p_older;
   logic signed [COEF_W+DRIVE_W-1:0] p_out1;
   logic signed [COEF_W+DRIVE_W-1:0] p_out2;
   logic signed [ACC_W-1:0]          acc;
   logic signed [ACC_W-1:0]          scaled;

   always_comb begin
      p_now   = coef.err_now   * err;
      p_prev  = coef.err_prev  * hist.err_prev;
      p_older = coef.err_older * hist.err_older;
      p_out1  = coef.out_prev  * hist.out_prev;
      p_out2  = coef.out_older * hist.out_older;

      // error terms carry an extra 2^16 so they line up with the output terms
      acc = (ACC_W'(p_now) <<< 16) + (ACC_W'(p_prev) <<< 16)
          + (ACC_W'(p_older) <<< 16) + ACC_W'(p_out1) + ACC_W'(p_out2)
          + ROUND_HALF;
      scaled = acc >>> COEF_FRAC_BITS;

      if (!scaled[ACC_W-1] && (|scaled[ACC_W-2:DRIVE_W-1])) begin
         drive = {1'b0, {(DRIVE_W-1){1'b1}}};
      end else if (scaled[ACC_W-1] && !(&scaled[ACC_W-2:DRIVE_W-1])) begin
         drive = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive = scaled[DRIVE_W-1:0];
      end
   end

endmodule

@@ sv/fwd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwd_port_checks
// Port-level checks on the regulator handshake and pipeline timing.
// ----------------------------------------------------------------------------
module fwd_port_checks import fwd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with no result pending the input side never stalls
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result stage");

   // every accepted request shows a result once past the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("result missing two cycles after request");

endmodule

bind front_wall_distance_regulator fwd_port_checks u_fwd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
